### rtl/lock_actuator_engage_sequencer_unit_macros.svh
// Assertion macros shared by the checker of the lock actuator engage sequencer.
`ifndef LOCK_ACTUATOR_ENGAGE_SEQUENCER_UNIT_MACROS_SVH
`define LOCK_ACTUATOR_ENGAGE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LAES_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// Next-cycle implication, disabled while reset is high.
`define LAES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons on the next cycle");

`endif

### rtl/laes_pkg.sv
// Package with the item types, register indexes and mode codes of the engage sequencer.
package laes_pkg;

   // Input item of one control tick.
   typedef struct packed {
      logic signed [31:0] raw_position;
      logic               engage_press;
      logic               disengage_press;
      logic               sensor_level;
      logic               homing_done;
   } req_type;

   // Result item of one control tick.
   typedef struct packed {
      logic signed [31:0] velocity_command;
      logic [2:0]         mode;
   } rsp_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_POSITION_OFFSET  = 3'd0;
   localparam logic [2:0] REG_ENGAGED_POSITION = 3'd1;
   localparam logic [2:0] REG_CLEARANCE        = 3'd2;
   localparam logic [2:0] REG_DRIVE_VELOCITY   = 3'd3;
   localparam logic [2:0] REG_MAX_TRIES        = 3'd4;
   localparam logic [2:0] REG_SPIN_UP_TICKS    = 3'd5;

   // Mode codes as seen on the result channel.
   localparam logic [2:0] MODE_UNHOMED_C     = 3'd0;
   localparam logic [2:0] MODE_DISENGAGED_C  = 3'd1;
   localparam logic [2:0] MODE_ENGAGING_C    = 3'd2;
   localparam logic [2:0] MODE_ENGAGED_C     = 3'd3;
   localparam logic [2:0] MODE_DISENGAGING_C = 3'd4;

   // Register reset values.
   localparam logic signed [31:0] ENGAGED_POSITION_RESET = 32'sd65536;
   localparam logic [15:0]        CLEARANCE_RESET        = 16'd3277;
   localparam logic [30:0]        DRIVE_VELOCITY_RESET   = 31'd65536;
   localparam logic [3:0]         MAX_TRIES_RESET        = 4'd1;
   localparam logic [7:0]         SPIN_UP_TICKS_RESET    = 8'd10;
   localparam logic [7:0]         WAIT_COUNT_RESET       = 8'd1;

endpackage

### rtl/lock_actuator_engage_sequencer_unit.sv
// Top level of the lock actuator engage sequencer: input stage, mode logic and result register.
//
//   channel  ports                               direction  content
//   req      req_valid, req_stall, req_data      in         one control tick
//   rsp      rsp_valid, rsp_stall, rsp_data      out        velocity command and mode
//   csr      csr_write_enable, csr_index, _data  in         register writes, no read-back
//
// One item per cycle while rsp_stall is low; each item passes the input register, then the result register.
// The offset subtraction runs into the input register, the mode logic into the result register.
// Reset is synchronous and restores the configuration registers, the handshake flags and the sequencer state.
// A stalled result holds the result register; the input register then holds too
// and req_stall rises only while both are full.
module lock_actuator_engage_sequencer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  laes_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output laes_pkg::rsp_type  rsp_data,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   typedef enum logic [2:0] {
      MODE_UNHOMED     = laes_pkg::MODE_UNHOMED_C,
      MODE_DISENGAGED  = laes_pkg::MODE_DISENGAGED_C,
      MODE_ENGAGING    = laes_pkg::MODE_ENGAGING_C,
      MODE_ENGAGED     = laes_pkg::MODE_ENGAGED_C,
      MODE_DISENGAGING = laes_pkg::MODE_DISENGAGING_C
   } mode_type;

   // Configuration registers.
   logic signed [31:0] position_offset_ff;
   logic signed [31:0] engaged_position_ff;
   logic [15:0]        clearance_ff;
   logic [30:0]        drive_velocity_ff;
   logic [3:0]         max_tries_ff;
   logic [7:0]         spin_up_ticks_ff;
   logic signed [32:0] threshold_ff;

   // Input stage.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic signed [31:0] pos_ff;
   logic signed [31:0] pos_in;
   logic               eng_press_ff;
   logic               dis_press_ff;
   logic               sensor_ff;
   logic               homed_ff;
   logic signed [32:0] pos_diff;
   logic               accept;
   logic               advance;

   // Sequencer state.
   mode_type           mode_ff;
   mode_type           mode_in;
   logic signed [31:0] last_position_ff;
   logic signed [31:0] velocity_ff;
   logic signed [31:0] velocity_in;
   logic               engage_pending_ff;
   logic               engage_pending_in;
   logic               disengage_pending_ff;
   logic               disengage_pending_in;
   logic [3:0]         attempts_left_ff;
   logic [3:0]         attempts_left_in;
   logic [7:0]         wait_count_ff;
   logic [7:0]         wait_count_in;

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   laes_pkg::rsp_type  rsp_data_ff;

   logic               still;
   logic               reached;
   logic               near_home;
   logic signed [31:0] vel_fwd;
   logic signed [31:0] vel_rev;
   logic [3:0]         tries_rem;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_offset_ff  <= '0;
         engaged_position_ff <= laes_pkg::ENGAGED_POSITION_RESET;
         clearance_ff        <= laes_pkg::CLEARANCE_RESET;
         drive_velocity_ff   <= laes_pkg::DRIVE_VELOCITY_RESET;
         max_tries_ff        <= laes_pkg::MAX_TRIES_RESET;
         spin_up_ticks_ff    <= laes_pkg::SPIN_UP_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            laes_pkg::REG_POSITION_OFFSET:  position_offset_ff  <= $signed(csr_write_data);
            laes_pkg::REG_ENGAGED_POSITION: engaged_position_ff <= $signed(csr_write_data);
            laes_pkg::REG_CLEARANCE:        clearance_ff        <= csr_write_data[15:0];
            laes_pkg::REG_DRIVE_VELOCITY:   drive_velocity_ff   <= csr_write_data[30:0];
            laes_pkg::REG_MAX_TRIES:        max_tries_ff        <= csr_write_data[3:0];
            laes_pkg::REG_SPIN_UP_TICKS:    spin_up_ticks_ff    <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // The engaged threshold only changes with the registers, so it is kept precomputed.
   always_ff @(posedge clock) begin
      threshold_ff <= {engaged_position_ff[31], engaged_position_ff}
                      - $signed({17'd0, clearance_ff});
   end

   // Handshake: the mode logic moves on when the result register is free or drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Offset position, saturated to the signed 32-bit range.
   always_comb begin
      pos_diff = {req_data.raw_position[31], req_data.raw_position}
                 - {position_offset_ff[31], position_offset_ff};
      if (pos_diff[32] != pos_diff[31]) begin
         pos_in = pos_diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
         pos_in = pos_diff[31:0];
      end
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff       <= pos_in;
         eng_press_ff <= req_data.engage_press;
         dis_press_ff <= req_data.disengage_press;
         sensor_ff    <= req_data.sensor_level;
         homed_ff     <= req_data.homing_done;
      end
   end

   // Position checks and velocity values.
   assign still     = (pos_ff == last_position_ff);
   assign reached   = ($signed({pos_ff[31], pos_ff}) >= threshold_ff);
   assign near_home = (pos_ff <= $signed({16'd0, clearance_ff}));
   assign vel_fwd   = $signed({1'b0, drive_velocity_ff});
   assign vel_rev   = -$signed({1'b0, drive_velocity_ff});
   assign tries_rem = (attempts_left_ff == 4'd0) ? 4'd0 : attempts_left_ff - 4'd1;

   // Mode logic for one tick.
   always_comb begin
      mode_in              = mode_ff;
      velocity_in          = velocity_ff;
      attempts_left_in     = attempts_left_ff;
      wait_count_in        = wait_count_ff;
      engage_pending_in    = engage_pending_ff
                             || (eng_press_ff && mode_ff == MODE_DISENGAGED);
      disengage_pending_in = disengage_pending_ff
                             || (dis_press_ff && mode_ff == MODE_ENGAGED);
      case (mode_ff)
         MODE_UNHOMED: begin
            if (homed_ff) begin
               mode_in     = MODE_DISENGAGED;
               velocity_in = '0;
            end
         end
         MODE_DISENGAGED: begin
            if (engage_pending_in) begin
               // A fresh request loads the attempt budget; a retry keeps it.
               if (attempts_left_ff == 4'd0) begin
                  attempts_left_in = (max_tries_ff == 4'd0) ? 4'd1 : max_tries_ff;
               end
               engage_pending_in = 1'b0;
               velocity_in       = vel_fwd;
               wait_count_in     = spin_up_ticks_ff;
               mode_in           = MODE_ENGAGING;
            end
         end
         MODE_ENGAGED: begin
            if (disengage_pending_in) begin
               disengage_pending_in = 1'b0;
               velocity_in          = vel_rev;
               mode_in              = MODE_DISENGAGING;
            end
         end
         MODE_ENGAGING: begin
            if (wait_count_ff == 8'd0) begin
               if (still) begin
                  if (reached) begin
                     velocity_in      = '0;
                     attempts_left_in = 4'd0;
                     mode_in          = MODE_ENGAGED;
                  end else begin
                     // Stalled short: back off, and retry while attempts remain.
                     velocity_in      = vel_rev;
                     mode_in          = MODE_DISENGAGING;
                     attempts_left_in = tries_rem;
                     if (tries_rem != 4'd0) begin
                        engage_pending_in = 1'b1;
                     end
                  end
               end
            end else begin
               wait_count_in = wait_count_ff - 8'd1;
            end
         end
         MODE_DISENGAGING: begin
            if (still && near_home && !sensor_ff) begin
               velocity_in = '0;
               mode_in     = MODE_DISENGAGED;
            end
         end
         default: ;
      endcase
   end

   // Sequencer state, handshake flags and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         mode_ff              <= MODE_UNHOMED;
         last_position_ff     <= '0;
         velocity_ff          <= '0;
         engage_pending_ff    <= 1'b0;
         disengage_pending_ff <= 1'b0;
         attempts_left_ff     <= 4'd0;
         wait_count_ff        <= laes_pkg::WAIT_COUNT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff                      <= mode_in;
            last_position_ff             <= pos_ff;
            velocity_ff                  <= velocity_in;
            engage_pending_ff            <= engage_pending_in;
            disengage_pending_ff         <= disengage_pending_in;
            attempts_left_ff             <= attempts_left_in;
            wait_count_ff                <= wait_count_in;
            rsp_data_ff.velocity_command <= velocity_in;
            rsp_data_ff.mode             <= mode_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/laes_checker.sv
// Port-level checker for the engage sequencer and its bind to the top level.
`include "lock_actuator_engage_sequencer_unit_macros.svh"

module laes_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input laes_pkg::rsp_type rsp_data
);

   // A stalled result stays offered and unchanged.
   `LAES_ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Resting modes never carry a drive command.
   `LAES_ASSERT_IMPLY(rest_zero_chk, clock, reset, rsp_valid && (rsp_data.mode == laes_pkg::MODE_UNHOMED_C || rsp_data.mode == laes_pkg::MODE_DISENGAGED_C || rsp_data.mode == laes_pkg::MODE_ENGAGED_C), rsp_data.velocity_command == 32'sd0)

   // Engaging always drives forward.
   `LAES_ASSERT_IMPLY(engaging_fwd_chk, clock, reset, rsp_valid && rsp_data.mode == laes_pkg::MODE_ENGAGING_C, rsp_data.velocity_command >= 32'sd0)

   // Disengaging always drives backward.
   `LAES_ASSERT_IMPLY(disengaging_rev_chk, clock, reset, rsp_valid && rsp_data.mode == laes_pkg::MODE_DISENGAGING_C, rsp_data.velocity_command <= 32'sd0)

endmodule

bind lock_actuator_engage_sequencer_unit laes_checker u_laes_checker (.*);
